// File: rtl/fde_pkg.sv
// Package for the feedback delay echo: sizes, register codes, pipeline structs
// and the rounding/saturation helpers.
// Used by every module of the block; depends on nothing.
package fde_pkg;

	// Core sizes. MAX_DELAY must be a power of two: line positions wrap naturally.
	localparam int MAX_DELAY   = 65536;
	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 24;

	localparam int PTR_W     = $clog2(MAX_DELAY);
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Gains are unsigned Q2.15; a gain register is wide enough to hold 1.0
	localparam int GAIN_SHIFT = 15;
	localparam int GAIN_W     = GAIN_SHIFT + 2;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(2 ** GAIN_SHIFT);

	// Configuration register widths
	localparam int DELAY_W = 17;
	localparam int FB_W    = 15;
	localparam int WET_W   = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(24000);
	localparam logic [FB_W-1:0]    FB_RESET    = FB_W'(16384);
	localparam logic [GAIN_W-1:0]  WET_RESET   = GAIN_W'(16384);

	// Products and sums: sample times a signed gain operand of GAIN_W+1 bits
	localparam int SUM_W = SAMPLE_BITS + GAIN_W + 1;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (GAIN_SHIFT - 1));
	localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'((2 ** (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN    = -SAT_MAX - SUM_W'(1);

	// Result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY    = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_WET      = 2'd2
	} cfg_reg_t;

	// Item leaving the line stage, delayed sample already resolved
	typedef struct packed {
		logic                          valid;
		logic [CH_W-1:0]               ch;
		logic [ADDR_W-1:0]             addr;
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] delayed;
	} line_item_t;

	// Write-back into the delay store
	typedef struct packed {
		logic                          en;
		logic [ADDR_W-1:0]             addr;
		logic signed [SAMPLE_BITS-1:0] data;
	} wr_port_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] y;
		logic [CH_W-1:0]               ch;
	} result_t;

	// Channel index modulo CHANNELS
	function automatic logic [CH_W-1:0] ch_reduce(input logic c);
		if (CHANNELS == 1)
			return '0;
		return CH_W'(c);
	endfunction

	// Clamp to the signed sample range
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SUM_W-1:0] v);
		if (v > SAT_MAX)
			return SAT_MAX[SAMPLE_BITS-1:0];
		if (v < SAT_MIN)
			return SAT_MIN[SAMPLE_BITS-1:0];
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

// File: rtl/fde_line.sv
// Delay line: per-channel write positions, fill tracking, the delay store and
// the read bypass. Depends on fde_pkg.
module fde_line (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [fde_pkg::SAMPLE_BITS-1:0] in_x,
	input  logic [fde_pkg::CH_W-1:0]              in_ch,
	input  logic [fde_pkg::PTR_W-1:0]             delay,
	input  fde_pkg::wr_port_t                     wb,
	output logic                                  hazard,
	output fde_pkg::line_item_t                   s1
);

	logic [fde_pkg::PTR_W-1:0]  wp_q [fde_pkg::CHANNELS];
	logic                       wrap_q [fde_pkg::CHANNELS];
	logic [fde_pkg::SAMPLE_BITS-1:0] mem [fde_pkg::MEM_DEPTH];

	logic [fde_pkg::PTR_W-1:0]  wp_sel;
	logic [fde_pkg::PTR_W-1:0]  rp;
	logic                       rd_ok;
	logic [fde_pkg::ADDR_W-1:0] rd_addr;
	logic [fde_pkg::ADDR_W-1:0] wr_addr;

	logic                                   valid_s1;
	logic [fde_pkg::CH_W-1:0]               ch_s1;
	logic [fde_pkg::ADDR_W-1:0]             addr_s1;
	logic [fde_pkg::ADDR_W-1:0]             rd_addr_s1;
	logic                                   rd_ok_s1;
	logic signed [fde_pkg::SAMPLE_BITS-1:0] x_s1;
	logic [fde_pkg::SAMPLE_BITS-1:0]        rdata_s1;
	fde_pkg::wr_port_t                      wb_q;

	// Read position and fill check: an entry was written if the channel wrapped
	// or it lies behind the write position
	always_comb begin
		wp_sel  = wp_q[in_ch];
		rp      = wp_sel - delay;
		rd_ok   = wrap_q[in_ch] || (rp < wp_sel);
		rd_addr = fde_pkg::ADDR_W'({in_ch, rp});
		wr_addr = fde_pkg::ADDR_W'({in_ch, wp_sel});
	end

	// The item one stage ahead writes back too late for a read issued now
	assign hazard = valid_s1 && (addr_s1 == rd_addr);

	// Write positions, wrap flags and the last write for bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fde_pkg::CHANNELS; i++) begin
				wp_q[i]   <= '0;
				wrap_q[i] <= 1'b0;
			end
			valid_s1 <= 1'b0;
			wb_q     <= '0;
		end else begin
			valid_s1 <= accept;
			wb_q     <= wb;
			if (accept) begin
				wp_q[in_ch] <= wp_sel + 1'b1;
				if (wp_sel == '1)
					wrap_q[in_ch] <= 1'b1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		ch_s1      <= in_ch;
		addr_s1    <= wr_addr;
		rd_addr_s1 <= rd_addr;
		rd_ok_s1   <= rd_ok;
		x_s1       <= in_x;
	end

	// Delay store: read before write on the same edge
	always_ff @(posedge clk) begin
		if (wb.en)
			mem[wb.addr] <= wb.data;
		rdata_s1 <= mem[rd_addr];
	end

	// Resolve delayed sample
	always_comb begin
		s1.valid = valid_s1;
		s1.ch    = ch_s1;
		s1.addr  = addr_s1;
		s1.x     = x_s1;
		if (!rd_ok_s1)
			s1.delayed = '0;
		else if (wb_q.en && (wb_q.addr == rd_addr_s1))
			s1.delayed = wb_q.data;
		else
			s1.delayed = rdata_s1;
	end

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> wp_q[$past(in_ch)] == $past(wp_sel + 1'b1))
		else $error("write position did not advance by one");

endmodule

// File: rtl/fde_mix.sv
// Gain and mix stage: three products, then rounding, saturation, write-back
// value and output sample. Depends on fde_pkg.
module fde_mix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fde_pkg::line_item_t            s1,
	input  logic [fde_pkg::FB_W-1:0]       fb,
	input  logic [fde_pkg::GAIN_W-1:0]     wet,
	input  logic [fde_pkg::GAIN_W-1:0]     dry,
	output fde_pkg::wr_port_t              wb,
	output logic                           res_valid,
	output fde_pkg::result_t               res
);

	logic signed [fde_pkg::SAMPLE_BITS-1:0] d_in;
	logic signed [fde_pkg::SAMPLE_BITS-1:0] x_in;
	logic signed [fde_pkg::GAIN_W:0]        fb_op;
	logic signed [fde_pkg::GAIN_W:0]        wet_op;
	logic signed [fde_pkg::GAIN_W:0]        dry_op;
	logic signed [fde_pkg::SUM_W-1:0]       fbp;
	logic signed [fde_pkg::SUM_W-1:0]       xp;
	logic signed [fde_pkg::SUM_W-1:0]       dp;

	logic                                   valid_s2;
	logic signed [fde_pkg::SUM_W-1:0]       fbp_s2;
	logic signed [fde_pkg::SUM_W-1:0]       xp_s2;
	logic signed [fde_pkg::SUM_W-1:0]       dp_s2;
	logic signed [fde_pkg::SAMPLE_BITS-1:0] x_s2;
	logic [fde_pkg::CH_W-1:0]               ch_s2;
	logic [fde_pkg::ADDR_W-1:0]             addr_s2;

	logic signed [fde_pkg::SUM_W-1:0]       x_ext;
	logic signed [fde_pkg::SUM_W-1:0]       fb_rnd;
	logic signed [fde_pkg::SUM_W-1:0]       y_rnd;

	// Products, all exact
	always_comb begin
		d_in   = s1.delayed;
		x_in   = s1.x;
		fb_op  = $signed({1'b0, fde_pkg::GAIN_W'(fb)});
		wet_op = $signed({1'b0, wet});
		dry_op = $signed({1'b0, dry});
		fbp    = d_in * fb_op;
		xp     = x_in * dry_op;
		dp     = d_in * wet_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= s1.valid;
	end

	always_ff @(posedge clk) begin
		fbp_s2  <= fbp;
		xp_s2   <= xp;
		dp_s2   <= dp;
		x_s2    <= s1.x;
		ch_s2   <= s1.ch;
		addr_s2 <= s1.addr;
	end

	// Round half up (floor shift), then clamp
	always_comb begin
		x_ext  = fde_pkg::SUM_W'(x_s2);
		fb_rnd = (fbp_s2 + fde_pkg::ROUND_HALF) >>> fde_pkg::GAIN_SHIFT;
		y_rnd  = (xp_s2 + dp_s2 + fde_pkg::ROUND_HALF) >>> fde_pkg::GAIN_SHIFT;
		wb.en   = valid_s2;
		wb.addr = addr_s2;
		wb.data = fde_pkg::sat_sample(x_ext + fb_rnd);
		res_valid = valid_s2;
		res.y     = fde_pkg::sat_sample(y_rnd);
		res.ch    = ch_s2;
	end

endmodule

// File: rtl/fde_out_fifo.sv
// Result queue between the pipeline and the output stream.
// Depends on fde_pkg.
module fde_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  fde_pkg::result_t              din,
	output logic                          out_valid,
	input  logic                          out_ready,
	output fde_pkg::result_t              dout,
	output logic [fde_pkg::OUT_CNT_W-1:0] count
);

	fde_pkg::result_t                 entry_q [fde_pkg::OUT_DEPTH];
	logic [fde_pkg::OUT_PTR_W-1:0]    wr_ptr_q;
	logic [fde_pkg::OUT_PTR_W-1:0]    rd_ptr_q;
	logic [fde_pkg::OUT_CNT_W-1:0]    count_q;
	logic                             pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = entry_q[rd_ptr_q];
	assign count     = count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (count_q == fde_pkg::OUT_CNT_W'(fde_pkg::OUT_DEPTH))))
		else $error("result queue overflow");

endmodule

// File: rtl/feedback_delay_echo_unit.sv
// Two-channel feedback echo over a whole-sample delay line. Takes one sample
// per cycle; each result passes through read, multiply, round and write back,
// then a four-entry result queue. The delay store's write-back comes from the
// second pipeline stage, after the matching read, so when a channel's delay is
// one sample and two transfers of that channel come in consecutive cycles, the
// second is held off. Input also waits while the result queue plus the two
// pipeline stages hold four results, which happens only when the output side
// stalls; every other pattern runs at one sample per cycle. The store needs
// no clearing pass: per-channel write positions and wrap flags mark unwritten
// entries, which read as zero.
// Depends on fde_pkg, fde_line, fde_mix and fde_out_fifo.
module feedback_delay_echo_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fde_pkg::SAMPLE_BITS-1:0] s_axis_tdata,  // [23:0] in_sample
	input  logic                            s_axis_tuser,  // [0] channel
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fde_pkg::SAMPLE_BITS-1:0] m_axis_tdata,  // [23:0] out_sample
	output logic                            m_axis_tuser,  // [0] out_channel
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fde_pkg::CFG_W-1:0]       cfg_data
);

	localparam int PEND_W = fde_pkg::OUT_CNT_W + 1;

	logic [fde_pkg::DELAY_W-1:0] delay_q;
	logic [fde_pkg::FB_W-1:0]    fb_q;
	logic [fde_pkg::GAIN_W-1:0]  wet_q;
	logic [fde_pkg::GAIN_W-1:0]  dry_q;
	logic [fde_pkg::GAIN_W-1:0]  wet_new;

	logic                           accept;
	logic                           hazard;
	logic [fde_pkg::CH_W-1:0]       ch_in;
	fde_pkg::line_item_t            s1;
	fde_pkg::wr_port_t              wb;
	logic                           res_valid;
	fde_pkg::result_t               res;
	fde_pkg::result_t               head;
	logic [fde_pkg::OUT_CNT_W-1:0]  q_count;
	logic [PEND_W-1:0]              pend;

	// Configuration registers; wet mix is clamped to 1.0 on write
	assign cfg_ready = 1'b1;
	assign wet_new = (cfg_data[fde_pkg::WET_W-1:0] > fde_pkg::WET_W'(fde_pkg::GAIN_ONE))
		? fde_pkg::GAIN_ONE : fde_pkg::GAIN_W'(cfg_data[fde_pkg::WET_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= fde_pkg::DELAY_RESET;
			fb_q    <= fde_pkg::FB_RESET;
			wet_q   <= fde_pkg::WET_RESET;
			dry_q   <= fde_pkg::GAIN_ONE - fde_pkg::WET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fde_pkg::cfg_reg_t'(cfg_index))
				fde_pkg::REG_DELAY: begin
					delay_q <= cfg_data[fde_pkg::DELAY_W-1:0];
				end
				fde_pkg::REG_FEEDBACK: begin
					fb_q <= cfg_data[fde_pkg::FB_W-1:0];
				end
				fde_pkg::REG_WET: begin
					wet_q <= wet_new;
					dry_q <= fde_pkg::GAIN_ONE - wet_new;
				end
				default: begin
				end
			endcase
		end
	end

	// Input transfer: room in the queue for everything in flight, no read hazard
	assign ch_in = fde_pkg::ch_reduce(s_axis_tuser);
	assign pend  = PEND_W'(q_count) + PEND_W'(s1.valid) + PEND_W'(wb.en);
	assign s_axis_tready = !hazard && (pend < PEND_W'(fde_pkg::OUT_DEPTH));
	assign accept = s_axis_tvalid && s_axis_tready;

	fde_line u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_x   ($signed(s_axis_tdata)),
		.in_ch  (ch_in),
		.delay  (fde_pkg::PTR_W'(delay_q)),
		.wb     (wb),
		.hazard (hazard),
		.s1     (s1)
	);

	fde_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.fb        (fb_q),
		.wet       (wet_q),
		.dry       (dry_q),
		.wb        (wb),
		.res_valid (res_valid),
		.res       (res)
	);

	fde_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dout      (head),
		.count     (q_count)
	);

	assign m_axis_tdata = head.y;
	assign m_axis_tuser = 1'(head.ch);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 res_valid)
		else $error("accepted sample produced no result two cycles later");

endmodule
